// ===== src/beam_optics_table_interpolator_assert.svh =====
// Assertion macros for the beam optics table
`ifndef BEAM_OPTICS_TABLE_INTERPOLATOR_ASSERT_SVH
`define BEAM_OPTICS_TABLE_INTERPOLATOR_ASSERT_SVH
// property that must hold on every clock edge outside reset
`define BOTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BOTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/boti_pkg.sv =====
// ----------------------------------------------------------------------------
// boti_pkg
// Shared types and constants of the beam optics table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package boti_pkg;
  localparam int unsigned TableRows = 64;

  localparam logic [1:0] OpClear    = 2'd0;
  localparam logic [1:0] OpLoad     = 2'd1;
  localparam logic [1:0] OpLookup   = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StEmpty     = 3'd1;
  localparam logic [2:0] StNotFound  = 3'd2;
  localparam logic [2:0] StOutRange  = 3'd3;
  localparam logic [2:0] StDuplicate = 3'd4;
  localparam logic [2:0] StFull      = 3'd5;
  localparam logic [2:0] StInvalid   = 3'd6;

  localparam logic signed [15:0] CorrOne = 16'sd16384;

  // one table row, energy key included
  typedef struct packed {
    logic [19:0]        energy;
    logic [19:0]        sigma_x;
    logic [19:0]        sigma_x_angle;
    logic signed [15:0] corr_x;
    logic [19:0]        sigma_y;
    logic [19:0]        sigma_y_angle;
    logic signed [15:0] corr_y;
    logic [15:0]        spread;
  } row_t;

  // divider control; num is the dividend above its 16 zero fraction bits
  typedef struct packed {
    logic        start;
    logic [19:0] num;
    logic [19:0] den;
  } div_req_t;
endpackage
`default_nettype wire

// ===== src/boti_div.sv =====
// ----------------------------------------------------------------------------
// boti_div
// Restoring divider, one quotient bit a cycle; 16-bit quotient of
// (num << 16) / den, where num is below den so the quotient fits.
// ----------------------------------------------------------------------------
`default_nettype none
module boti_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire boti_pkg::div_req_t req_i,
  output logic                   done_o,
  output logic [15:0]            quot_o
);
  logic [20:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [19:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [20:0] trial;

  // numerator low 16 bits are zero; the high 20 bits are below den
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    trial = {rem_q[19:0], 1'b0} - {1'b0, den_q};
    if (run_q) begin
      if (!trial[20] || rem_q[20]) begin
        rem_d = trial;
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[19:0], 1'b0};
        quo_d = {quo_q[14:0], 1'b0};
      end
      rem_d[20] = 1'b0;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= run_q && (cnt_q == 5'd1);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= 5'd16;
      end else begin
        run_q <= run_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      quo_q <= '0;
      den_q <= req_i.den;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== src/beam_optics_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// beam_optics_table_interpolator
// Sorted beam optics table with exact and piecewise linear lookup.
// ----------------------------------------------------------------------------
// One request at a time; busy is high from acceptance until the result
// strobe. Clear and requests rejected up front go straight to the done
// state. The memory read is registered, so every scan or shift step takes
// a read state and a wait state per row. Load scans all held rows, then
// moves the rows above the insertion point up one by one (a full-table
// reject ends after the scan). An exact lookup ends at the matching row.
// An interpolation scans up to the upper bracketing row, waits on the
// 16-step divider and runs seven multiplies on one shared 17x22 multiplier.
// The result is shown for one cycle on done_o and must be taken then.
`default_nettype none
module beam_optics_table_interpolator #(
  parameter int unsigned TABLE_ROWS = boti_pkg::TableRows
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation_i,
  input  wire logic [19:0]        energy_i,
  input  wire logic               interpolate_i,
  input  wire logic [19:0]        sigma_x_i,
  input  wire logic [19:0]        sigma_x_angle_i,
  input  wire logic signed [15:0] corr_x_i,
  input  wire logic [19:0]        sigma_y_i,
  input  wire logic [19:0]        sigma_y_angle_i,
  input  wire logic signed [15:0] corr_y_i,
  input  wire logic [15:0]        energy_spread_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [19:0]             out_energy_o,
  output logic [19:0]             out_sigma_x_o,
  output logic [19:0]             out_sigma_x_angle_o,
  output logic signed [15:0]      out_corr_x_o,
  output logic [19:0]             out_sigma_y_o,
  output logic [19:0]             out_sigma_y_angle_o,
  output logic signed [15:0]      out_corr_y_o,
  output logic [15:0]             out_energy_spread_o
);
  localparam int unsigned AW = $clog2(TABLE_ROWS);
  localparam int unsigned CW = $clog2(TABLE_ROWS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_SCANW = 10'b0000000100,
    S_SHIFT = 10'b0000001000,
    S_SHW   = 10'b0000010000,
    S_PAIR  = 10'b0000100000,
    S_PAIRW = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_MUL   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q;
  boti_pkg::row_t mem [TABLE_ROWS];
  boti_pkg::row_t rd_q, lo_q, in_q;
  logic [CW-1:0] count_q, idx_q, pos_q;
  logic          pos_set_q;
  logic [1:0]    op_q;
  logic          interp_q;
  logic [2:0]    st_q;
  boti_pkg::row_t res_q;
  logic [15:0]   t_q;
  logic [2:0]    mi_q;
  logic signed [37:0] prod_q;
  logic          mvalid_q;
  logic [2:0]    mwi_q;
  boti_pkg::div_req_t dreq;
  logic          ddone;
  logic [15:0]   dquot;

  // memory: one read, one write per cycle
  logic          we;
  logic [AW-1:0] wa, ra;
  boti_pkg::row_t wd;
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  boti_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  // multiplier operand select
  logic signed [20:0] a_s, b_s;
  always_comb begin
    case (mi_q)
      3'd0: begin a_s = {1'b0, lo_q.sigma_x};       b_s = {1'b0, rd_q.sigma_x}; end
      3'd1: begin a_s = {1'b0, lo_q.sigma_x_angle}; b_s = {1'b0, rd_q.sigma_x_angle}; end
      3'd2: begin a_s = 21'(lo_q.corr_x);           b_s = 21'(rd_q.corr_x); end
      3'd3: begin a_s = {1'b0, lo_q.sigma_y};       b_s = {1'b0, rd_q.sigma_y}; end
      3'd4: begin a_s = {1'b0, lo_q.sigma_y_angle}; b_s = {1'b0, rd_q.sigma_y_angle}; end
      3'd5: begin a_s = 21'(lo_q.corr_y);           b_s = 21'(rd_q.corr_y); end
      default: begin a_s = {5'd0, lo_q.spread};     b_s = {5'd0, rd_q.spread}; end
    endcase
  end
  logic signed [21:0] diff;
  assign diff = 22'(b_s) - 22'(a_s);

  // base value for the registered product
  logic signed [20:0] base_s;
  always_comb begin
    case (mwi_q)
      3'd0: base_s = {1'b0, lo_q.sigma_x};
      3'd1: base_s = {1'b0, lo_q.sigma_x_angle};
      3'd2: base_s = 21'(lo_q.corr_x);
      3'd3: base_s = {1'b0, lo_q.sigma_y};
      3'd4: base_s = {1'b0, lo_q.sigma_y_angle};
      3'd5: base_s = 21'(lo_q.corr_y);
      default: base_s = {5'd0, lo_q.spread};
    endcase
  end
  logic signed [21:0] lerp_v;
  assign lerp_v = 22'(base_s) + 22'(prod_q >>> 16);

  logic corr_bad, accept;
  assign corr_bad = (corr_x_i < -boti_pkg::CorrOne) || (corr_x_i > boti_pkg::CorrOne) ||
                    (corr_y_i < -boti_pkg::CorrOne) || (corr_y_i > boti_pkg::CorrOne);
  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);

  always_comb begin
    we = 1'b0;
    wa = pos_q[AW-1:0];
    wd = in_q;
    ra = idx_q[AW-1:0];
    dreq.start = 1'b0;
    dreq.num = in_q.energy - lo_q.energy;
    dreq.den = rd_q.energy - lo_q.energy;
    case (state_q)
      S_SHIFT: ra = AW'(idx_q - CW'(1));
      S_SHW: begin
        we = 1'b1;
        wa = idx_q[AW-1:0];
        wd = rd_q;
        if (idx_q == pos_q) wd = in_q;
      end
      S_PAIR, S_DIV, S_MUL: ra = pos_q[AW-1:0];
      S_PAIRW: begin
        ra = pos_q[AW-1:0];
        dreq.start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_o <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      mvalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (accept) begin
          op_q <= operation_i;
          interp_q <= interpolate_i;
          in_q <= '{energy_i, sigma_x_i, sigma_x_angle_i, corr_x_i, sigma_y_i,
                    sigma_y_angle_i, corr_y_i, energy_spread_i};
          res_q <= '0;
          idx_q <= '0;
          pos_set_q <= 1'b0;
          pos_q <= count_q;
          st_q <= boti_pkg::StOk;
          state_q <= S_DONE;
          if (operation_i == boti_pkg::OpClear) count_q <= '0;
          else if (operation_i == boti_pkg::OpLoad) begin
            if (energy_i == '0 || corr_bad) st_q <= boti_pkg::StInvalid;
            else if (count_q != '0) state_q <= S_SCAN;
            else state_q <= S_SHIFT;
          end else if (operation_i == boti_pkg::OpLookup) begin
            if (count_q == '0) st_q <= boti_pkg::StEmpty;
            else state_q <= S_SCAN;
          end else st_q <= boti_pkg::StInvalid;
        end
        S_SCAN: state_q <= S_SCANW;  // read of idx_q in flight
        S_SCANW: begin
          state_q <= S_SCAN;
          idx_q <= idx_q + CW'(1);
          if (rd_q.energy == in_q.energy) begin
            if (op_q == boti_pkg::OpLoad) st_q <= boti_pkg::StDuplicate;
            else res_q <= rd_q;
            state_q <= S_DONE;
          end else if (rd_q.energy > in_q.energy && !pos_set_q) begin
            pos_set_q <= 1'b1;
            pos_q <= idx_q;
            if (op_q == boti_pkg::OpLookup) begin
              if (!interp_q) st_q <= boti_pkg::StNotFound;
              else if (idx_q == '0) st_q <= boti_pkg::StOutRange;
              else state_q <= S_PAIR;
              if (!interp_q || idx_q == '0) state_q <= S_DONE;
            end
          end else if (op_q == boti_pkg::OpLookup) lo_q <= rd_q;
          if (idx_q == count_q - CW'(1) && state_q == S_SCANW &&
              rd_q.energy != in_q.energy &&
              !(op_q == boti_pkg::OpLookup && rd_q.energy > in_q.energy && !pos_set_q)) begin
            if (op_q == boti_pkg::OpLookup) begin
              st_q <= interp_q ? boti_pkg::StOutRange : boti_pkg::StNotFound;
              state_q <= S_DONE;
            end else if (count_q >= CW'(TABLE_ROWS)) begin
              st_q <= boti_pkg::StFull;
              state_q <= S_DONE;
            end else begin
              idx_q <= count_q;
              state_q <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (count_q >= CW'(TABLE_ROWS)) begin
            st_q <= boti_pkg::StFull;
            state_q <= S_DONE;
          end else begin
            if (!pos_set_q) idx_q <= count_q;
            pos_set_q <= 1'b1;
            state_q <= S_SHW;
          end
        end
        S_SHW: begin
          if (idx_q == pos_q) begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q - CW'(1);
            state_q <= S_SHIFT;
          end
        end
        S_PAIR: state_q <= S_PAIRW;  // re-read upper row at pos_q
        S_PAIRW: begin
          mi_q <= 3'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ddone) begin
            t_q <= dquot;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= 38'(signed'({1'b0, t_q})) * 38'(diff);
          mvalid_q <= 1'b1;
          mwi_q <= mi_q;
          mi_q <= mi_q + 3'd1;
          if (mi_q == 3'd6) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!mvalid_q) begin
            done_o <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (mvalid_q) begin
        case (mwi_q)
          3'd0: res_q.sigma_x <= lerp_v[19:0];
          3'd1: res_q.sigma_x_angle <= lerp_v[19:0];
          3'd2: res_q.corr_x <= lerp_v[15:0];
          3'd3: res_q.sigma_y <= lerp_v[19:0];
          3'd4: res_q.sigma_y_angle <= lerp_v[19:0];
          3'd5: res_q.corr_y <= lerp_v[15:0];
          default: res_q.spread <= lerp_v[15:0];
        endcase
      end
    end
  end

  // the scan read address tracks idx_q; pair state reads pos_q
  assign status_o            = st_q;
  assign out_energy_o        = in_q.energy;
  assign out_sigma_x_o       = (st_q == boti_pkg::StOk) ? res_q.sigma_x : '0;
  assign out_sigma_x_angle_o = (st_q == boti_pkg::StOk) ? res_q.sigma_x_angle : '0;
  assign out_corr_x_o        = (st_q == boti_pkg::StOk) ? res_q.corr_x : '0;
  assign out_sigma_y_o       = (st_q == boti_pkg::StOk) ? res_q.sigma_y : '0;
  assign out_sigma_y_angle_o = (st_q == boti_pkg::StOk) ? res_q.sigma_y_angle : '0;
  assign out_corr_y_o        = (st_q == boti_pkg::StOk) ? res_q.corr_y : '0;
  assign out_energy_spread_o = (st_q == boti_pkg::StOk) ? res_q.spread : '0;

`include "beam_optics_table_interpolator_assert.svh"
  `BOTI_ASSERT(a_count_bound, count_q <= CW'(TABLE_ROWS), "row count beyond table size")
  `BOTI_ASSERT_NEXT(a_strobe_single, done_o, !done_o, "result strobe longer than a cycle")
  `BOTI_ASSERT(a_no_accept_busy, !(done_o && state_q != S_IDLE), "busy during strobe")
endmodule
`default_nettype wire
